>>> sv/erpm_pkg.sv
// Package for the encoder rpm moving-average core.
// Widths, window depth, speed constant, mode and register codes, shared types.
// No dependencies.
package erpm_pkg;

	localparam int WIN_DEPTH = 8;
	localparam int SLOT_W    = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
	localparam int CNT_W     = $clog2(WIN_DEPTH + 1);
	localparam int SPEED_W   = 32;
	localparam int SUM_W     = SPEED_W + SLOT_W;
	localparam int NUM_W     = 34;
	localparam int DIV_NW    = (SUM_W > NUM_W) ? SUM_W : NUM_W;
	localparam int DEN_W     = 48;
	localparam int ITER_W    = $clog2(DIV_NW);

	// 60e6 * 256: rpm in 24.8 fixed point
	localparam logic [NUM_W-1:0] RPM_NUMERATOR = 34'd15360000000;

	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_EVAL  = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	localparam logic [1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [1:0] REG_PPR      = 2'd1;
	localparam logic [1:0] REG_TIMEOUT  = 2'd2;

	localparam logic [15:0]        DEBOUNCE_RST = 16'd50;
	localparam logic [15:0]        PPR_RST      = 16'd11;
	localparam logic [SPEED_W-1:0] TIMEOUT_RST  = 32'd500000;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

>>> sv/erpm_div.sv
// Restoring divider, one quotient bit per cycle.
// Zero divisor yields an all-ones quotient. Depends on erpm_pkg.
module erpm_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [erpm_pkg::DIV_NW-1:0] dividend,
	input  logic [erpm_pkg::DEN_W-1:0]  divisor,
	output logic [erpm_pkg::DIV_NW-1:0] quotient,
	output erpm_pkg::div_stat_t       stat
);
	import erpm_pkg::*;

	logic [DEN_W:0]    rem_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DEN_W-1:0]  dvs_q;
	logic [ITER_W-1:0] iter_q;
	logic              busy_q;
	logic              done_q;
	logic [DEN_W:0]    rem_sh;
	logic [DEN_W+1:0]  diff;

	assign rem_sh = {rem_q[DEN_W-1:0], quo_q[DIV_NW-1]};
	assign diff   = {1'b0, rem_sh} - {2'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= ITER_W'(DIV_NW - 1);
			end else if (busy_q) begin
				iter_q <= iter_q - 1'b1;
				if (iter_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[DEN_W+1]) begin
				rem_q <= diff[DEN_W:0];
				quo_q <= {quo_q[DIV_NW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[DIV_NW-2:0], 1'b0};
			end
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

>>> sv/encoder_rpm_moving_average_core.sv
// Encoder rpm meter with moving-average window: top level.
// One item is one microsecond tick; the result is one transfer per item.
// Depends on erpm_pkg and erpm_div.
//
// An item that computes a new speed makes two divisions on the shared restoring divider:
// the rpm quotient, then the window mean. Only the mean is divided when no speed is pushed,
// an old or zero speed is pushed before the mean is divided, and no division is made when
// the window is empty. s_tready is high only between items.
// The finished result waits in the output register and the next item is taken meanwhile.
// An item holds in its last cycle only while the previous result is still waiting.
// Configuration is written through cfg_we; the user must write it only while idle, the block does not enforce it.
module encoder_rpm_moving_average_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [1:0] mode, [2] edge_req, [7:3] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata    // [31:0] average_rpm, [63:32] instant_rpm
);
	import erpm_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_TICK   = 4'd1;
	localparam logic [3:0] S_EVAL   = 4'd2;
	localparam logic [3:0] S_MUL    = 4'd3;
	localparam logic [3:0] S_RPM_GO = 4'd4;
	localparam logic [3:0] S_RPM_WT = 4'd5;
	localparam logic [3:0] S_PUSH   = 4'd6;
	localparam logic [3:0] S_AVG_GO = 4'd7;
	localparam logic [3:0] S_AVG_WT = 4'd8;
	localparam logic [3:0] S_FIN    = 4'd9;

	logic [3:0]         state_q;
	logic [15:0]        debounce_q;
	logic [15:0]        ppr_q;
	logic [SPEED_W-1:0] timeout_q;
	logic [1:0]         mode_q;
	logic               edge_q;
	logic [SPEED_W-1:0] since_q;
	logic [SPEED_W-1:0] period_q;
	logic               pending_q;
	logic [SPEED_W-1:0] speed_q;
	logic [SPEED_W-1:0] win_q [WIN_DEPTH];
	logic [SLOT_W-1:0]  slot_q;
	logic               full_q;
	logic [SUM_W-1:0]   sum_q;
	logic [DEN_W-1:0]   den_q;
	logic [SPEED_W-1:0] avg_q;
	logic               out_valid_q;
	logic [SPEED_W-1:0] out_avg_q;
	logic [SPEED_W-1:0] out_inst_q;

	logic [SPEED_W-1:0] since_inc;
	logic [CNT_W-1:0]   count;
	logic               fin_load;
	logic               div_start;
	logic [DIV_NW-1:0]  div_dividend;
	logic [DEN_W-1:0]   div_divisor;
	logic [DIV_NW-1:0]  div_quo;
	div_stat_t          div_stat;

	assign since_inc = (since_q == '1) ? since_q : since_q + 1'b1;
	assign count     = full_q ? CNT_W'(WIN_DEPTH) : CNT_W'(slot_q);
	assign fin_load  = (state_q == S_FIN) && (!out_valid_q || m_tready);

	assign div_start    = (state_q == S_RPM_GO) || (state_q == S_AVG_GO && count != '0);
	assign div_dividend = (state_q == S_RPM_GO) ? DIV_NW'(RPM_NUMERATOR) : DIV_NW'(sum_q);
	assign div_divisor  = (state_q == S_RPM_GO) ? den_q : DEN_W'(count);

	erpm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RST;
			ppr_q      <= PPR_RST;
			timeout_q  <= TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEBOUNCE: debounce_q <= cfg_data[15:0];
				REG_PPR:      ppr_q      <= cfg_data[15:0];
				REG_TIMEOUT:  timeout_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			since_q     <= '0;
			period_q    <= '0;
			pending_q   <= 1'b0;
			speed_q     <= '0;
			slot_q      <= '0;
			full_q      <= 1'b0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < WIN_DEPTH; i++) win_q[i] <= '0;
		end else begin
			if (fin_load) out_valid_q <= 1'b1;
			else if (m_tvalid && m_tready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) state_q <= S_TICK;
				end
				S_TICK: begin
					if (edge_q && since_inc > SPEED_W'(debounce_q)) begin
						period_q  <= since_inc;
						since_q   <= '0;
						pending_q <= 1'b1;
					end else begin
						since_q <= since_inc;
					end
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					state_q <= S_AVG_GO;
					if (mode_q == MODE_EVAL) begin
						if (pending_q) begin
							pending_q <= 1'b0;
							state_q   <= (period_q != '0) ? S_MUL : S_PUSH;
						end else if (since_q > timeout_q) begin
							speed_q <= '0;
							state_q <= S_PUSH;
						end
					end else if (mode_q == MODE_CLEAR) begin
						slot_q <= '0;
						full_q <= 1'b0;
						sum_q  <= '0;
						for (int i = 0; i < WIN_DEPTH; i++) win_q[i] <= '0;
					end
				end
				S_MUL:    state_q <= S_RPM_GO;
				S_RPM_GO: state_q <= S_RPM_WT;
				S_RPM_WT: begin
					if (div_stat.done) begin
						speed_q <= (|div_quo[DIV_NW-1:SPEED_W]) ? '1 : div_quo[SPEED_W-1:0];
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					sum_q         <= sum_q - SUM_W'(win_q[slot_q]) + SUM_W'(speed_q);
					win_q[slot_q] <= speed_q;
					if (slot_q == SLOT_W'(WIN_DEPTH - 1)) begin
						slot_q <= '0;
						full_q <= 1'b1;
					end else begin
						slot_q <= slot_q + 1'b1;
					end
					state_q <= S_AVG_GO;
				end
				S_AVG_GO: state_q <= (count != '0) ? S_AVG_WT : S_FIN;
				S_AVG_WT: begin
					if (div_stat.done) state_q <= S_FIN;
				end
				S_FIN: begin
					if (fin_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid) begin
			mode_q <= s_tdata[1:0];
			edge_q <= s_tdata[2];
		end
		if (state_q == S_MUL) den_q <= DEN_W'(ppr_q) * DEN_W'(period_q);
		if (state_q == S_AVG_GO) avg_q <= '0;
		else if (state_q == S_AVG_WT && div_stat.done) avg_q <= div_quo[SPEED_W-1:0];
		if (fin_load) begin
			out_avg_q  <= avg_q;
			out_inst_q <= speed_q;
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_inst_q, out_avg_q};

endmodule

>>> sv/erpm_checker.sv
// Port-level checks for the encoder rpm moving-average core, bound to the top level.
// Depends only on the top-level ports.
module erpm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata
);

	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in work");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	a_result_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(s_tready) |-> m_tvalid)
		else $error("item finished without a result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && s_tready |=> !m_tvalid)
		else $error("result appeared with no item in work");

	logic unused_in;
	assign unused_in = ^s_tdata;

endmodule

bind encoder_rpm_moving_average_core erpm_checker u_erpm_checker (.*);

>>> sim/tb_encoder_rpm_moving_average_core.sv
// Self-checking testbench for encoder_rpm_moving_average_core: tick stream in, rpm pairs out.
// A scoreboard class predicts period, speed and window mean for every transfer.
// Depends on erpm_pkg and the core RTL.
module tb_encoder_rpm_moving_average_core;
	timeunit 1ns;
	timeprecision 1ps;
	import erpm_pkg::*;

	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int HOLD_LEN = 1500;

	typedef struct {
		logic [31:0] average_rpm;
		logic [31:0] instant_rpm;
	} rpm_sample_t;

	class rpm_scoreboard;
		logic [15:0] min_gap_us = DEBOUNCE_RST;
		logic [15:0] pulses_per_rev = PPR_RST;
		logic [31:0] stop_timeout_us = TIMEOUT_RST;
		logic [31:0] since_edge_us = '0;
		logic [31:0] period_us = '0;
		logic pending = 1'b0;
		logic [31:0] speed_now = '0;
		logic [31:0] win[WIN_DEPTH] = '{default: '0};
		int unsigned slot = 0;
		logic full = 1'b0;
		logic [63:0] window_sum = '0;
		rpm_sample_t expected_q[$];
		int mismatches = 0;

		function void set_regs(logic [15:0] d, logic [15:0] p, logic [31:0] t);
			min_gap_us = d;
			pulses_per_rev = p;
			stop_timeout_us = t;
		endfunction

		function logic [31:0] speed_of(logic [31:0] period);
			logic [63:0] den;
			logic [63:0] q;
			den = 64'(pulses_per_rev) * 64'(period);
			if (den == 0)
				return 32'hFFFF_FFFF;
			q = 64'(RPM_NUMERATOR) / den;
			return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
		endfunction

		function void push_speed(logic [31:0] v);
			window_sum = window_sum - 64'(win[slot]) + 64'(v);
			win[slot] = v;
			if (slot == WIN_DEPTH - 1) begin
				slot = 0;
				full = 1'b1;
			end else begin
				slot++;
			end
		endfunction

		function void clear_window();
			foreach (win[i])
				win[i] = '0;
			slot = 0;
			full = 1'b0;
			window_sum = '0;
		endfunction

		function void note_tick(logic [1:0] mode, logic pulse);
			int unsigned fill;
			rpm_sample_t s;
			if (since_edge_us != 32'hFFFF_FFFF)
				since_edge_us++;
			if (pulse && since_edge_us > 32'(min_gap_us)) begin
				period_us = since_edge_us;
				since_edge_us = '0;
				pending = 1'b1;
			end
			if (mode == MODE_EVAL) begin
				if (pending) begin
					pending = 1'b0;
					if (period_us != 0)
						speed_now = speed_of(period_us);
					push_speed(speed_now);
				end else if (since_edge_us > stop_timeout_us) begin
					speed_now = '0;
					push_speed('0);
				end
			end else if (mode == MODE_CLEAR) begin
				clear_window();
			end
			fill = full ? WIN_DEPTH : slot;
			s.average_rpm = (fill != 0) ? 32'(window_sum / fill) : '0;
			s.instant_rpm = speed_now;
			expected_q.push_back(s);
		endfunction

		function void check_result(logic [63:0] data);
			rpm_sample_t e;
			if (expected_q.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result transfer: %h", data);
				mismatches++;
				return;
			end
			e = expected_q.pop_front();
			if (data[31:0] !== e.average_rpm || data[63:32] !== e.instant_rpm) begin
				if (mismatches < 10)
					$display("mismatch: average exp %h got %h, instant exp %h got %h",
						e.average_rpm, data[31:0], e.instant_rpm, data[63:32]);
				mismatches++;
			end
		endfunction

		function int pending_results();
			return expected_q.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;   // [1:0] mode, [2] edge_req, [7:3] zero
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;        // [31:0] average_rpm, [63:32] instant_rpm

	rpm_scoreboard sb = new();
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_cnt = 0;

	encoder_rpm_moving_average_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99, 0) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	task automatic send_tick(logic [1:0] mode, logic pulse);
		s_tvalid <= 1'b1;
		s_tdata <= {5'b0, pulse, mode};
		do @(posedge clk); while (!s_tready);
		sb.note_tick(mode, pulse);
		if ($urandom_range(99, 0) < idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99, 0) < idle_pct);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending_results() != 0);
	endtask

	task automatic program_regs(logic [15:0] d, logic [15:0] p, logic [31:0] t);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= REG_DEBOUNCE;
		cfg_data <= {16'd0, d};
		@(posedge clk);
		cfg_index <= REG_PPR;
		cfg_data <= {16'd0, p};
		@(posedge clk);
		cfg_index <= REG_TIMEOUT;
		cfg_data <= t;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_regs(d, p, t);
	endtask

	task automatic run_random(int n, int idle, int stall, int hold);
		int r;
		logic [1:0] mode;
		idle_pct = idle;
		stall_pct = stall;
		hold_cnt = hold;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99, 0);
			if (r < 50)
				mode = MODE_EVAL;
			else if (r < 85)
				mode = MODE_TICK;
			else if (r < 93)
				mode = MODE_CLEAR;
			else
				mode = MODE_SPARE;
			if (i == n / 2)
				drain();
			send_tick(mode, $urandom_range(99, 0) < 35);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: edge inside debounce, eval with nothing to push, spare mode
		send_tick(MODE_EVAL, 1'b1);
		send_tick(MODE_TICK, 1'b0);
		send_tick(MODE_SPARE, 1'b1);

		// zero ppr saturates, zero timeout pushes zero, clear keeps speed
		program_regs(16'd0, 16'd0, 32'd0);
		send_tick(MODE_EVAL, 1'b1);
		send_tick(MODE_EVAL, 1'b0);
		send_tick(MODE_TICK, 1'b1);
		send_tick(MODE_CLEAR, 1'b1);
		send_tick(MODE_EVAL, 1'b0);
		repeat (9) send_tick(MODE_EVAL, 1'b1);

		program_regs(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
		send_tick(MODE_EVAL, 1'b1);
		send_tick(MODE_SPARE, 1'b0);
		send_tick(MODE_TICK, 1'b1);

		program_regs(16'd0, 16'hFFFF, 32'hFFFF_FFFF);
		repeat (3) send_tick(MODE_EVAL, 1'b1);

		program_regs(16'($urandom_range(4, 0)), 16'($urandom_range(20, 1)),
			32'($urandom_range(20, 0)));
		run_random(100, 0, 0, HOLD_LEN);

		program_regs(16'($urandom_range(12, 0)), 16'hFFFF, 32'hFFFF_FFFF);
		run_random(100, 74, 0, 0);

		program_regs(16'd3, 16'd1, 32'($urandom_range(50, 5)));
		run_random(100, 0, 74, 0);

		program_regs(16'($urandom_range(8, 0)), 16'($urandom_range(65535, 1)),
			32'($urandom_range(100, 0)));
		run_random(100, 12, 12, 0);

		drain();
		repeat (200) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_results() == 0) begin
			$display("tb_encoder_rpm_moving_average_core: clean");
		end else begin
			$display("tb_encoder_rpm_moving_average_core: errors");
		end
		$finish;
	end

	initial begin
		#500_000;
		$display("tb_encoder_rpm_moving_average_core: errors");
		$finish;
	end

endmodule

>>> filelist.f
sv/erpm_pkg.sv
sv/erpm_div.sv
sv/encoder_rpm_moving_average_core.sv
sv/erpm_checker.sv
sim/tb_encoder_rpm_moving_average_core.sv
